@@ hw/rtl/slpc_pkg.sv @@
// Shared types and constants for the status LED pattern controller.
// Used by slpc_cfg_regs, slpc_core and status_led_pattern_controller.
package slpc_pkg;

  localparam int COUNT_BITS_DEF = 12;

  localparam int BLINK_W  = 8;
  localparam int FLASH_W  = 8;
  localparam int STALE_W  = 12;
  localparam int PERIOD_W = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_BOOT_HALF   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STALE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BEAT_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW  = 3'd4;

  localparam logic [BLINK_W-1:0]  RST_BOOT_HALF   = 8'd5;
  localparam logic [FLASH_W-1:0]  RST_FLASH       = 8'd2;
  localparam logic [STALE_W-1:0]  RST_STALE       = 12'd50;
  localparam logic [PERIOD_W-1:0] RST_BEAT_PERIOD = 12'd50;
  localparam logic                RST_ACTIVE_LOW  = 1'b1;

  typedef enum logic [1:0] {
    MODE_FAULT = 2'd0,
    MODE_BOOT  = 2'd1,
    MODE_RUN   = 2'd2
  } mode_t;

  typedef struct packed {
    logic [BLINK_W-1:0]  boot_half;
    logic [FLASH_W-1:0]  flash;
    logic [STALE_W-1:0]  stale;
    logic [PERIOD_W-1:0] beat_period;
    logic                active_low;
  } cfg_t;

  typedef struct packed {
    logic kick;
    logic set_ready;
    logic activity;
    logic fault_write;
    logic fault_value;
  } evt_t;

  typedef struct packed {
    logic  led_on;
    logic  pin_level;
    mode_t mode;
  } res_t;

endpackage

@@ hw/rtl/slpc_cfg_regs.sv @@
// Configuration register file of the status LED pattern controller.
// Depends on slpc_pkg for register indexes, widths and reset values.
module slpc_cfg_regs
  import slpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_idx,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_idx)
        REG_BOOT_HALF:   cfg_nxt.boot_half   = wr_data[BLINK_W-1:0];
        REG_FLASH:       cfg_nxt.flash       = wr_data[FLASH_W-1:0];
        REG_STALE:       cfg_nxt.stale       = wr_data[STALE_W-1:0];
        REG_BEAT_PERIOD: cfg_nxt.beat_period = wr_data[PERIOD_W-1:0];
        REG_ACTIVE_LOW:  cfg_nxt.active_low  = wr_data[0];
        default:         cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.boot_half   <= RST_BOOT_HALF;
      cfg_r.flash       <= RST_FLASH;
      cfg_r.stale       <= RST_STALE;
      cfg_r.beat_period <= RST_BEAT_PERIOD;
      cfg_r.active_low  <= RST_ACTIVE_LOW;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/slpc_core.sv @@
// Tick state and LED decision logic of the status LED pattern controller.
// Depends on slpc_pkg; state advances on each committed tick.
module slpc_core
  import slpc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  evt_t evt,
  input  logic commit,
  output res_t res
);

  localparam int CMP_W = (COUNT_BITS > STALE_W) ? COUNT_BITS : STALE_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [BLINK_W-1:0]    blink_count_r, blink_count_nxt;
  logic                  blink_phase_r, blink_phase_nxt;
  logic [COUNT_BITS-1:0] since_kick_r, since_kick_nxt;
  logic [COUNT_BITS-1:0] beat_wait_r, beat_wait_nxt;
  logic [FLASH_W-1:0]    flash_left_r, flash_left_nxt;
  logic                  ready_r, ready_nxt;
  logic                  fault_r, fault_nxt;
  logic                  act_pend_r, act_pend_nxt;

  logic [COUNT_BITS-1:0] sk;
  logic [COUNT_BITS-1:0] bw;
  logic [FLASH_W-1:0]    fl;
  logic [COUNT_BITS-1:0] beat_sat;
  logic [BLINK_W-1:0]    blink_inc;
  logic                  alive;
  logic                  led;
  mode_t                 mode;

  assign beat_sat = (CMP_W'(cfg.beat_period) > CMP_W'(CNT_MAX)) ? CNT_MAX
                                                                : COUNT_BITS'(cfg.beat_period);

  always_comb begin
    sk           = evt.kick ? '0 : since_kick_r;
    ready_nxt    = ready_r | evt.set_ready;
    act_pend_nxt = act_pend_r | evt.activity;
    fault_nxt    = evt.fault_write ? evt.fault_value : fault_r;
    bw           = beat_wait_r;
    fl           = flash_left_r;
    alive        = CMP_W'(sk) < CMP_W'(cfg.stale);
    led          = 1'b0;
    mode         = MODE_RUN;
    if (fault_nxt) begin
      mode = MODE_FAULT;
      led  = 1'b1;
    end else if (!ready_nxt) begin
      mode = MODE_BOOT;
      led  = ~blink_phase_r;
    end else begin
      if (act_pend_nxt) begin
        fl           = cfg.flash;
        act_pend_nxt = 1'b0;
      end
      if (alive && (bw == '0)) begin
        fl = cfg.flash;
        bw = beat_sat;
      end
      led = alive && (fl != '0);
    end
  end

  always_comb begin
    since_kick_nxt  = (sk != CNT_MAX) ? sk + COUNT_BITS'(1) : sk;
    beat_wait_nxt   = (bw != '0) ? bw - COUNT_BITS'(1) : bw;
    flash_left_nxt  = (fl != '0) ? fl - FLASH_W'(1) : fl;
    blink_inc       = blink_count_r + BLINK_W'(1);
    blink_count_nxt = blink_inc;
    blink_phase_nxt = blink_phase_r;
    if (blink_inc >= cfg.boot_half) begin
      blink_count_nxt = '0;
      blink_phase_nxt = ~blink_phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_count_r <= '0;
      blink_phase_r <= 1'b0;
      since_kick_r  <= '0;
      beat_wait_r   <= '0;
      flash_left_r  <= '0;
      ready_r       <= 1'b0;
      fault_r       <= 1'b0;
      act_pend_r    <= 1'b0;
    end else if (commit) begin
      blink_count_r <= blink_count_nxt;
      blink_phase_r <= blink_phase_nxt;
      since_kick_r  <= since_kick_nxt;
      beat_wait_r   <= beat_wait_nxt;
      flash_left_r  <= flash_left_nxt;
      ready_r       <= ready_nxt;
      fault_r       <= fault_nxt;
      act_pend_r    <= act_pend_nxt;
    end
  end

  assign res.led_on    = led;
  assign res.pin_level = led ^ cfg.active_low;
  assign res.mode      = mode;

endmodule

@@ hw/rtl/status_led_pattern_controller.sv @@
// Status LED pattern controller: one transaction per loop tick in, one LED
// result per tick out. Input register, decision logic, result register.
// Depends on slpc_pkg, slpc_cfg_regs and slpc_core.
//
// Input channel (in_valid/in_stall) carries the events seen since the last
// tick: kick, set_ready, activity, fault_write with fault_value.
// Result channel (out_valid/out_stall) returns led_on, pin_level and mode
// (0 fault solid, 1 boot blink, 2 running heartbeat) for each tick.
// Configuration channel (cfg_valid/cfg_ready) writes one register by index;
// cfg_ready is always high. Write only while no tick is in flight.
// Flow: an accepted tick waits in the input register and moves into the
// result register once that is free. Throughput: one tick per cycle while
// out_stall is low, limited by the single input and result registers.
// Reset: synchronous, active low; all counters and flags clear, the
// registers return to 5, 2, 50, 50 and active low.
// Stall: a stalled result holds; one more tick is taken into the input
// register, after which in_stall rises until the result is taken.
module status_led_pattern_controller
  import slpc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kick,
  input  logic                  in_set_ready,
  input  logic                  in_activity,
  input  logic                  in_fault_write,
  input  logic                  in_fault_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_led_on,
  output logic                  out_pin_level,
  output logic [1:0]            out_mode,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  evt_t s1_evt_r;
  logic s1_vld_r;
  res_t core_res;
  res_t out_res_r;
  logic out_vld_r;
  logic out_free;
  logic s1_adv;
  logic in_acc;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_vld_r || !out_stall;
  assign s1_adv    = s1_vld_r && out_free;
  assign in_stall  = s1_vld_r && !out_free;
  assign in_acc    = in_valid && !in_stall;

  slpc_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  slpc_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .evt    (s1_evt_r),
    .commit (s1_adv),
    .res    (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_evt_r.kick        <= in_kick;
      s1_evt_r.set_ready   <= in_set_ready;
      s1_evt_r.activity    <= in_activity;
      s1_evt_r.fault_write <= in_fault_write;
      s1_evt_r.fault_value <= in_fault_value;
    end
    if (s1_adv) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_led_on    = out_res_r.led_on;
  assign out_pin_level = out_res_r.pin_level;
  assign out_mode      = out_res_r.mode;

  a_fault_lit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_res_r.mode == MODE_FAULT)) |-> out_res_r.led_on)
    else $error("fault mode result with LED dark");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_vld_r)
    else $error("committed tick produced no result");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && out_vld_r && out_stall))
    else $error("input stalled without a blocked result");

endmodule

@@ dv/slpc_led_monitor.sv @@
// Transaction monitor for the status LED pattern controller: predicts each LED result
// from the accepted ticks and register writes, and compares it with the result port.
// Depends on slpc_pkg; instantiated by tb beside the controller.
module slpc_led_monitor
  import slpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_kick,
  input  logic                  in_set_ready,
  input  logic                  in_activity,
  input  logic                  in_fault_write,
  input  logic                  in_fault_value,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_led_on,
  input  logic                  out_pin_level,
  input  logic [1:0]            out_mode,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [BLINK_W-1:0]        boot_half_r;
  logic [FLASH_W-1:0]        flash_r;
  logic [STALE_W-1:0]        stale_r;
  logic [PERIOD_W-1:0]       beat_period_r;
  logic                      active_low_r;

  logic [BLINK_W-1:0]        blink_cnt;
  logic                      blink_ph;
  logic [COUNT_BITS_DEF-1:0] since_kick_cnt;
  logic [COUNT_BITS_DEF-1:0] beat_cnt;
  logic [FLASH_W-1:0]        flash_cnt;
  logic                      ready_q;
  logic                      fault_q;
  logic                      act_q;

  res_t led_expected[$];

  function automatic res_t led_decide(input evt_t ev);
    res_t r;
    logic alive;
    logic lit;
    if (ev.kick) since_kick_cnt = '0;
    if (ev.set_ready) ready_q = 1'b1;
    if (ev.activity) act_q = 1'b1;
    if (ev.fault_write) fault_q = ev.fault_value;
    if (fault_q) begin
      r.mode = MODE_FAULT;
      lit = 1'b1;
    end else if (!ready_q) begin
      r.mode = MODE_BOOT;
      lit = !blink_ph;
    end else begin
      alive = since_kick_cnt < stale_r;
      r.mode = MODE_RUN;
      if (act_q) begin
        flash_cnt = flash_r;
        act_q = 1'b0;
      end
      if (alive && beat_cnt == '0) begin
        flash_cnt = flash_r;
        beat_cnt = beat_period_r;
      end
      lit = alive && flash_cnt != '0;
    end
    r.led_on = lit;
    r.pin_level = lit ^ active_low_r;
    // advance the time counters, whatever the mode
    if (since_kick_cnt != '1) since_kick_cnt = since_kick_cnt + COUNT_BITS_DEF'(1);
    if (beat_cnt != '0) beat_cnt = beat_cnt - COUNT_BITS_DEF'(1);
    if (flash_cnt != '0) flash_cnt = flash_cnt - FLASH_W'(1);
    blink_cnt = blink_cnt + BLINK_W'(1);
    if (blink_cnt >= boot_half_r) begin
      blink_cnt = '0;
      blink_ph = !blink_ph;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    evt_t tick_ev;
    res_t want;
    if (!rst_n) begin
      boot_half_r = RST_BOOT_HALF;
      flash_r = RST_FLASH;
      stale_r = RST_STALE;
      beat_period_r = RST_BEAT_PERIOD;
      active_low_r = RST_ACTIVE_LOW;
      blink_cnt = '0;
      blink_ph = 1'b0;
      since_kick_cnt = '0;
      beat_cnt = '0;
      flash_cnt = '0;
      ready_q = 1'b0;
      fault_q = 1'b0;
      act_q = 1'b0;
      led_expected.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BOOT_HALF:   boot_half_r = cfg_data[BLINK_W-1:0];
          REG_FLASH:       flash_r = cfg_data[FLASH_W-1:0];
          REG_STALE:       stale_r = cfg_data[STALE_W-1:0];
          REG_BEAT_PERIOD: beat_period_r = cfg_data[PERIOD_W-1:0];
          REG_ACTIVE_LOW:  active_low_r = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        tick_ev.kick = in_kick;
        tick_ev.set_ready = in_set_ready;
        tick_ev.activity = in_activity;
        tick_ev.fault_write = in_fault_write;
        tick_ev.fault_value = in_fault_value;
        led_expected.push_back(led_decide(tick_ev));
      end
      if (out_valid && !out_stall) begin
        if (led_expected.size() == 0) begin
          $error("result with no tick pending");
          fail_count++;
        end else begin
          want = led_expected.pop_front();
          if (out_led_on !== want.led_on) begin
            $error("led_on: expected %0d, actual %0d", want.led_on, out_led_on);
            fail_count++;
          end
          if (out_pin_level !== want.pin_level) begin
            $error("pin_level: expected %0d, actual %0d", want.pin_level, out_pin_level);
            fail_count++;
          end
          if (out_mode !== want.mode) begin
            $error("mode: expected %0d, actual %0d", want.mode, out_mode);
            fail_count++;
          end
        end
      end
      pending = led_expected.size();
    end
  end

endmodule

@@ dv/tb.sv @@
// Top of the status LED pattern controller testbench: clock, reset, tick and
// register stimulus with random idling on both channels, and the final verdict.
// Depends on slpc_pkg, status_led_pattern_controller and slpc_led_monitor.
module tb;
  import slpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RUN_PHASES = 7;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_kick;
  logic                  in_set_ready;
  logic                  in_activity;
  logic                  in_fault_write;
  logic                  in_fault_value;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_led_on;
  logic                  out_pin_level;
  logic [1:0]            out_mode;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int cycles = 0;
  int rx_hold = 0;
  bit rx_calm = 1'b0;
  bit tx_calm = 1'b0;

  int run_stale[RUN_PHASES] = '{50, 0, 4095, 1, 20, -1, -1};
  int run_beat[RUN_PHASES]  = '{50, 0, 0, 1, 4095, -1, -1};
  int run_flash[RUN_PHASES] = '{2, 255, 1, 0, 255, -1, -1};
  int run_low[RUN_PHASES]   = '{1, 0, 1, 0, 1, -1, -1};
  int run_kick[RUN_PHASES]  = '{30, 20, 5, 50, 3, 10, 40};
  int boot_half[4] = '{0, 1, 255, -1};
  int boot_len[4]  = '{40, 40, 270, 60};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  status_led_pattern_controller uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kick       (in_kick),
    .in_set_ready  (in_set_ready),
    .in_activity   (in_activity),
    .in_fault_write(in_fault_write),
    .in_fault_value(in_fault_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_led_on    (out_led_on),
    .out_pin_level (out_pin_level),
    .out_mode      (out_mode),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  slpc_led_monitor u_monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kick       (in_kick),
    .in_set_ready  (in_set_ready),
    .in_activity   (in_activity),
    .in_fault_write(in_fault_write),
    .in_fault_value(in_fault_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_led_on    (out_led_on),
    .out_pin_level (out_pin_level),
    .out_mode      (out_mode),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // hold each result back for a random stall, with calm spells of no stall
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      rx_hold = rx_calm ? 0 : $urandom_range(0, 14);
    end else if (out_valid && rx_hold != 0) begin
      rx_hold--;
    end
  end

  always @(negedge clk) begin
    out_stall <= (rx_hold != 0);
  end

  function automatic evt_t mk_tick(input bit k, input bit r, input bit a, input bit fw,
                                   input bit fv);
    evt_t e;
    e.kick = k;
    e.set_ready = r;
    e.activity = a;
    e.fault_write = fw;
    e.fault_value = fv;
    return e;
  endfunction

  function automatic evt_t rand_tick(input bit allow_ready, input int kick_pct);
    evt_t e;
    e.kick = $urandom_range(0, 99) < kick_pct;
    e.set_ready = allow_ready && $urandom_range(0, 3) == 0;
    e.activity = $urandom_range(0, 5) == 0;
    e.fault_write = $urandom_range(0, 9) == 0;
    e.fault_value = e.fault_write ? ($urandom_range(0, 3) == 0) : 1'($urandom_range(0, 1));
    return e;
  endfunction

  task automatic send_tick(input evt_t e);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kick <= e.kick;
    in_set_ready <= e.set_ready;
    in_activity <= e.activity;
    in_fault_write <= e.fault_write;
    in_fault_value <= e.fault_value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain_ticks();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_unused();
    write_reg(CFG_IDX_W'(REG_ACTIVE_LOW + 1 + $urandom_range(0, 2)), CFG_DATA_W'($urandom));
  endtask

  initial begin
    int v;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kick = 1'b0;
    in_set_ready = 1'b0;
    in_activity = 1'b0;
    in_fault_write = 1'b0;
    in_fault_value = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // boot blink, activity held while not ready, fault set and clear
    repeat (6) send_tick(mk_tick(0, 0, 0, 0, 0));
    send_tick(mk_tick(0, 0, 1, 0, 0));
    send_tick(mk_tick(0, 0, 0, 1, 1));
    send_tick(mk_tick(0, 0, 1, 0, 0));
    send_tick(mk_tick(0, 0, 0, 0, 1));
    send_tick(mk_tick(0, 0, 0, 1, 0));
    send_tick(mk_tick(1, 0, 0, 0, 0));
    drain_ticks();

    for (int p = 0; p < 4; p++) begin
      v = (boot_half[p] < 0) ? $urandom_range(2, 20) : boot_half[p];
      write_reg(REG_BOOT_HALF, {4'($urandom), 8'(v)});
      write_unused();
      for (int i = 0; i < boot_len[p]; i++) send_tick(rand_tick(1'b0, 30));
      drain_ticks();
    end

    // enter running mode with the pending activity, then heartbeat and fault
    send_tick(mk_tick(1, 1, 0, 0, 0));
    repeat (4) send_tick(mk_tick(0, 0, 0, 0, 0));
    send_tick(mk_tick(0, 0, 1, 0, 0));
    send_tick(mk_tick(1, 1, 1, 1, 1));
    send_tick(mk_tick(0, 0, 0, 1, 0));
    repeat (2) send_tick(mk_tick(0, 0, 0, 0, 0));
    drain_ticks();

    for (int p = 0; p < RUN_PHASES; p++) begin
      write_reg(REG_BOOT_HALF, {4'($urandom), 8'($urandom_range(0, 255))});
      v = (run_flash[p] < 0) ? $urandom_range(0, 20) : run_flash[p];
      write_reg(REG_FLASH, {4'($urandom), 8'(v)});
      v = (run_stale[p] < 0) ? $urandom_range(1, 120) : run_stale[p];
      write_reg(REG_STALE, 12'(v));
      v = (run_beat[p] < 0) ? $urandom_range(0, 60) : run_beat[p];
      write_reg(REG_BEAT_PERIOD, 12'(v));
      v = (run_low[p] < 0) ? $urandom_range(0, 1) : run_low[p];
      write_reg(REG_ACTIVE_LOW, {11'($urandom), 1'(v)});
      write_unused();
      for (int i = 0; i < 90; i++) send_tick(rand_tick(1'b1, run_kick[p]));
      drain_ticks();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
